// ===== sv/sse_pkg.sv =====
// Shared types and constants for the sorted set engine.
// Used by sse_ctrl, sse_datapath and sorted_set_engine; depends on nothing.
`default_nettype none

package sse_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;
    localparam int REQ_W    = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // apply the captured request and load the result register
    } sse_cmd_t;

endpackage

`default_nettype wire

// ===== sv/sse_datapath.sv =====
// Datapath of the sorted set engine: request register, the row of key cells
// with parallel compare and shift, the entry count and the result register.
// Depends on sse_pkg.
`default_nettype none

module sse_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sse_pkg::sse_cmd_t             cmd,
    input  wire logic [sse_pkg::REQ_W-1:0]     req_type,
    input  wire logic [sse_pkg::KEY_W-1:0]     key,
    output logic                               success,
    output logic                               full_reject,
    output logic [sse_pkg::OUT_CNT_W-1:0]      entry_count
);

    logic [sse_pkg::REQ_W-1:0]    op_reg;
    logic [sse_pkg::KEY_W-1:0]    key_reg;
    logic [sse_pkg::KEY_W-1:0]    keys_reg [sse_pkg::CAPACITY];
    logic [sse_pkg::CNT_W-1:0]    count_reg;
    logic [sse_pkg::CNT_W-1:0]    count_next;
    logic                         success_reg;
    logic                         full_reject_reg;
    logic [sse_pkg::OUT_CNT_W-1:0] entry_count_reg;

    logic [sse_pkg::CAPACITY-1:0] lt;
    logic [sse_pkg::CAPACITY-1:0] eq;
    logic                         hit;
    logic                         is_full;
    logic                         do_ins;
    logic                         do_del;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req_type;
            key_reg <= key;
        end
    end

    // Every cell compares against the request key at once. Since the held keys
    // are ascending, lt forms a run of ones from cell 0 up to the key's position.
    genvar gi;
    generate
        for (gi = 0; gi < sse_pkg::CAPACITY; gi++)
        begin : g_cmp
            logic valid;
            assign valid  = sse_pkg::CNT_W'(gi) < count_reg;
            assign lt[gi] = valid && (keys_reg[gi] < key_reg);
            assign eq[gi] = valid && (keys_reg[gi] == key_reg);
        end
    endgenerate

    assign hit     = |eq;
    assign is_full = count_reg == sse_pkg::CNT_W'(sse_pkg::CAPACITY);
    assign do_ins  = (op_reg == sse_pkg::REQ_INSERT) && !hit && !is_full;
    assign do_del  = (op_reg == sse_pkg::REQ_DELETE) && hit;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + sse_pkg::CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - sse_pkg::CNT_W'(1);
        end
    end

    // Insert opens a gap at the key's position by moving the upper cells up;
    // delete closes it by moving them down. Cells below the position keep.
    generate
        for (gi = 0; gi < sse_pkg::CAPACITY; gi++)
        begin : g_cell
            always_ff @(posedge clk)
            begin
                if (cmd.exec && !lt[gi])
                begin
                    if (do_ins)
                    begin
                        if (gi == 0)
                        begin
                            keys_reg[gi] <= key_reg;
                        end
                        else if (lt[(gi == 0) ? 0 : gi - 1])
                        begin
                            keys_reg[gi] <= key_reg;
                        end
                        else
                        begin
                            keys_reg[gi] <= keys_reg[(gi == 0) ? 0 : gi - 1];
                        end
                    end
                    else if (do_del && (gi < sse_pkg::CAPACITY - 1))
                    begin
                        keys_reg[gi] <= keys_reg[(gi < sse_pkg::CAPACITY - 1) ? gi + 1 : gi];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            success_reg     <= do_ins || do_del ||
                               ((op_reg == sse_pkg::REQ_SEARCH) && hit);
            full_reject_reg <= (op_reg == sse_pkg::REQ_INSERT) && !hit && is_full;
            entry_count_reg <= sse_pkg::OUT_CNT_W'(count_next);
        end
    end

    assign success     = success_reg;
    assign full_reject = full_reject_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

// ===== sv/sse_ctrl.sv =====
// Controller of the sorted set engine: request handshake, execute step and
// the valid flag of the result register. Depends on sse_pkg.
`default_nettype none

module sse_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output sse_pkg::sse_cmd_t       cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   slot_free;

    // The result register may be refilled in the same cycle it is drained.
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec  = (state_reg == ST_EXEC) && slot_free;
    assign m_tvalid  = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cmd.exec)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/sorted_set_engine.sv =====
// Top level of the sorted set engine: ties the controller to the datapath.
// Depends on sse_pkg, sse_ctrl and sse_datapath.
//
// Usage:
//   Requests enter on the slave stream: s_tuser carries the request type
//   (insert, delete, search) and s_tdata the key. A request is taken at an
//   edge where s_tvalid and s_tready are both high.
//   Each request gives exactly one result on the master stream: m_tdata
//   holds the success bit, the full flag and the entry count after the
//   request. The result leaves when m_tvalid and m_tready are both high.
//   The request is captured in the idle state; the result becomes valid at
//   the execute step that follows, in which all key cells compare in
//   parallel and shift. A new request is only taken once that execute step
//   is done. The next request is taken while a result waits in the output
//   register; if the receiver stalls, the execute step waits until the
//   output register can be refilled, and s_tready stays low meanwhile.
//   Reset empties the set (count zero) and drops any pending result; key
//   cells are not cleared, since only cells below the count are ever used.
`default_nettype none

module sorted_set_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sse_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] key
    input  wire logic [sse_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sse_pkg::M_DATA_W-1:0]       m_tdata    // [0] success, [1] full_reject,
                                                          // [6:2] entry_count, [7] zero
);

    sse_pkg::sse_cmd_t                cmd;
    logic                             success;
    logic                             full_reject;
    logic [sse_pkg::OUT_CNT_W-1:0]    entry_count;

    sse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sse_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (s_tuser),
        .key         (s_tdata[sse_pkg::KEY_W-1:0]),
        .success     (success),
        .full_reject (full_reject),
        .entry_count (entry_count)
    );

    assign m_tdata = {1'b0, entry_count, full_reject, success};

endmodule

`default_nettype wire
